>>> hdl/utf8rs_pkg.sv
package utf8rs_pkg;

    localparam int unsigned CP_W = 21;

    localparam logic [CP_W-1:0] LAST_CP_LEN1 = 21'h00007F;
    localparam logic [CP_W-1:0] LAST_CP_LEN2 = 21'h0007FF;
    localparam logic [CP_W-1:0] LAST_CP_LEN3 = 21'h00FFFF;
    localparam logic [CP_W-1:0] LAST_CP      = 21'h10FFFF;
    localparam logic [7:0] LEAD_LEN2 = 8'hC0;
    localparam logic [7:0] LEAD_LEN3 = 8'hE0;
    localparam logic [7:0] LEAD_LEN4 = 8'hF0;
    localparam logic [7:0] INFIX = 8'h80;
    localparam logic [5:0] MASK = 6'h3F;
    localparam int unsigned SHIFT = 6;

    typedef struct packed {
        logic [CP_W-1:0] range_low;
        logic [CP_W-1:0] range_high;
    } t_in_item;

    typedef struct packed {
        logic [2:0] seq_length;
        logic [7:0] byte0_low;
        logic [7:0] byte0_high;
        logic [7:0] byte1_low;
        logic [7:0] byte1_high;
        logic [7:0] byte2_low;
        logic [7:0] byte2_high;
        logic [7:0] byte3_low;
        logic [7:0] byte3_high;
        logic       last_piece;
    } t_out_item;

    typedef enum logic [1:0] {
        S_IDLE,
        S_START,
        S_SEARCH
    } t_state;

    typedef logic [3:0][7:0] t_bytes;

    function automatic logic [2:0] seq_len(input logic [CP_W-1:0] c);
        if (c <= LAST_CP_LEN1) begin
            return 3'd1;
        end else if (c <= LAST_CP_LEN2) begin
            return 3'd2;
        end else if (c <= LAST_CP_LEN3) begin
            return 3'd3;
        end
        return 3'd4;
    endfunction

    function automatic logic [CP_W-1:0] top_of_len(input logic [2:0] n);
        logic [CP_W-1:0] t;
        case (n)
            3'd1: t = LAST_CP_LEN1;
            3'd2: t = LAST_CP_LEN2;
            3'd3: t = LAST_CP_LEN3;
            default: t = LAST_CP;
        endcase
        return t;
    endfunction

    // low bits covered by k trailing continuation bytes
    function automatic logic [CP_W-1:0] mask_of(input logic [2:0] k);
        logic [CP_W-1:0] m;
        case (k)
            3'd0: m = 21'h000000;
            3'd1: m = 21'h00003F;
            3'd2: m = 21'h000FFF;
            3'd3: m = 21'h03FFFF;
            default: m = 21'h1FFFFF;
        endcase
        return m;
    endfunction

    function automatic t_bytes encode(input logic [CP_W-1:0] c);
        t_bytes b;
        b = '0;
        if (c <= LAST_CP_LEN1) begin
            b[0] = c[7:0];
        end else if (c <= LAST_CP_LEN2) begin
            b[0] = LEAD_LEN2 | {3'b000, c[10:6]};
            b[1] = INFIX | {2'b00, c[5:0] & MASK};
        end else if (c <= LAST_CP_LEN3) begin
            b[0] = LEAD_LEN3 | {4'b0000, c[15:12]};
            b[1] = INFIX | {2'b00, c[11:6] & MASK};
            b[2] = INFIX | {2'b00, c[5:0] & MASK};
        end else begin
            b[0] = LEAD_LEN4 | {5'b00000, c[20:18]};
            b[1] = INFIX | {2'b00, c[17:12] & MASK};
            b[2] = INFIX | {2'b00, c[11:6] & MASK};
            b[3] = INFIX | {2'b00, c[5:0] & MASK};
        end
        return b;
    endfunction

endpackage

>>> hdl/utf8_range_splitter_unit.sv
// Splits one inclusive code point range into the ascending sub-ranges whose UTF-8 forms are
// plain catenations of byte ranges, one output transaction per sub-range with the last one
// flagged; an inverted range yields nothing and inputs above 0x10FFFF saturate. A range is
// taken only while the unit is idle and gives up to 16 sub-ranges. Each sub-range passes a
// setup state and then a search in the shared bound compare, which tries candidate
// alignments from the widest continuation group down to single code points, and waits there
// while the output is stalled. An inverted range leaves the unit idle; after any other range
// the next range is taken the cycle after the last sub-range enters the output register.
module utf8_range_splitter_unit
    import utf8rs_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_in_item  i_in_data,
    output logic      o_in_stall,
    output logic      o_out_valid,
    output t_out_item o_out_data,
    input  logic      i_out_stall
);

    t_state          r_state, n_state;
    logic [CP_W-1:0] r_lo, n_lo;
    logic [CP_W-1:0] r_hi, n_hi;
    logic [CP_W-1:0] r_seg, n_seg;
    logic [2:0]      r_n, n_n;
    logic [1:0]      r_k, n_k;
    logic            r_out_valid, n_out_valid;
    t_out_item       r_out, n_out;

    logic [CP_W-1:0] w_in_lo, w_in_hi;
    logic            w_in_take;
    logic            w_out_free;
    logic [CP_W-1:0] w_seg;
    logic [1:0]      w_kmax;
    logic [CP_W:0]   w_round;
    logic            w_fits;
    logic [CP_W-1:0] w_rend;
    logic [CP_W-1:0] w_a;
    logic [CP_W-1:0] w_end;
    logic            w_load;
    logic            w_last;
    t_bytes          w_lb, w_hb;

    assign w_in_lo = (i_in_data.range_low > LAST_CP) ? LAST_CP : i_in_data.range_low;
    assign w_in_hi = (i_in_data.range_high > LAST_CP) ? LAST_CP : i_in_data.range_high;
    assign w_in_take  = (r_state == S_IDLE) && i_in_valid;
    assign w_out_free = !r_out_valid || !i_out_stall;

    // end of the current same-length segment
    assign w_seg = (r_n < seq_len(r_hi)) ? top_of_len(r_n) : r_hi;

    // widest aligned group of trailing continuation bytes at r_lo
    always_comb begin
        w_kmax = 2'd0;
        for (int i = 1; i < 4; i++) begin
            if ((3'(i) < r_n) && ((r_lo & mask_of(3'(i))) == '0)) begin
                w_kmax = 2'(i);
            end
        end
    end

    // shared bound unit: candidate sub-range end for group size r_k
    assign w_round = ({1'b0, r_seg} + {{CP_W{1'b0}}, 1'b1}) & ~{1'b0, mask_of({1'b0, r_k})};
    assign w_fits  = w_round > {1'b0, r_lo};
    assign w_rend  = CP_W'(w_round - {{CP_W{1'b0}}, 1'b1});
    assign w_a     = (({1'b0, r_k} + 3'd1) < r_n) ? (r_lo | mask_of({1'b0, r_k} + 3'd1)) : r_seg;
    assign w_end   = (w_a < w_rend) ? w_a : w_rend;
    assign w_load  = (r_state == S_SEARCH) && w_fits && w_out_free;
    assign w_last  = (w_end == r_hi);
    assign w_lb    = encode(r_lo);
    assign w_hb    = encode(w_end);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_take && (w_in_lo <= w_in_hi)) begin
                    n_state = S_START;
                end
            end
            S_START: begin
                n_state = S_SEARCH;
            end
            S_SEARCH: begin
                if (w_load) begin
                    n_state = w_last ? S_IDLE : S_START;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_seg       = r_seg;
        n_n         = r_n;
        n_k         = r_k;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        case (r_state)
            S_IDLE: begin
                if (w_in_take) begin
                    n_lo = w_in_lo;
                    n_hi = w_in_hi;
                    n_n  = seq_len(w_in_lo);
                end
            end
            S_START: begin
                n_seg = w_seg;
                n_k   = w_kmax;
            end
            S_SEARCH: begin
                if (!w_fits) begin
                    n_k = r_k - 2'd1;
                end else if (w_out_free) begin
                    n_out_valid      = 1'b1;
                    n_out.seq_length = r_n;
                    n_out.byte0_low  = w_lb[0];
                    n_out.byte0_high = w_hb[0];
                    n_out.byte1_low  = w_lb[1];
                    n_out.byte1_high = w_hb[1];
                    n_out.byte2_low  = w_lb[2];
                    n_out.byte2_high = w_hb[2];
                    n_out.byte3_low  = w_lb[3];
                    n_out.byte3_high = w_hb[3];
                    n_out.last_piece = w_last;
                    n_lo             = w_end + CP_W'(1);
                    if (w_end == r_seg) begin
                        n_n = r_n + 3'd1;
                    end
                end
            end
            default: begin
                n_out_valid = r_out_valid && i_out_stall;
            end
        endcase
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo  <= n_lo;
        r_hi  <= n_hi;
        r_seg <= n_seg;
        r_n   <= n_n;
        r_k   <= n_k;
        r_out <= n_out;
    end

    a_search_in_segment: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEARCH) |-> (r_lo <= r_seg) && (r_seg <= r_hi))
        else $error("sub-range start beyond segment end");

    a_len_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEARCH) |-> (r_n == seq_len(r_lo)) && (r_n == seq_len(r_seg)))
        else $error("sequence length does not match current code points");

    a_last_goes_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && w_last) |=> (r_state == S_IDLE))
        else $error("sequencer busy after final sub-range");

    a_out_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.seq_length >= 3'd1) && (r_out.seq_length <= 3'd4))
        else $error("bad sequence length on output");

    a_lead_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.byte0_low <= r_out.byte0_high))
        else $error("leading byte range inverted");

endmodule
